@@ hdl/thpt_pkg.sv @@
// Shared types, codes and helpers for the tunnel half-context pairing table.
// Used by thpt_cell and tunnel_half_context_pairing_table_top. No dependencies.
`default_nettype none

package thpt_pkg;

    localparam logic [1:0] OP_ACCESS_ADD = 2'd0;
    localparam logic [1:0] OP_ACCESS_DEL = 2'd1;
    localparam logic [1:0] OP_CORE_ADD   = 2'd2;
    localparam logic [1:0] OP_CORE_DEL   = 2'd3;

    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_COMPLETE = 3'd1;
    localparam logic [2:0] ST_REJECT   = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_DELETE   = 3'd4;

    localparam logic [15:0] REMOTE_PORT_RESET = 16'd2152;

    typedef struct packed {
        logic [63:0] sub;
        logic [3:0]  sub_len;
        logic [3:0]  bearer;
        logic [31:0] user_ip;
        logic [31:0] station_ip;
        logic [31:0] gateway_ip;
        logic [15:0] gateway_port;
        logic [31:0] station_teid;
        logic [31:0] access_teid;
        logic [31:0] core_local_teid;
        logic [31:0] core_remote_teid;
    } entry_t;

    typedef struct packed {
        logic [1:0] opcode;
        entry_t     fields;
    } req_t;

    typedef struct packed {
        logic [31:0] ue_addr;
        logic [31:0] enb_addr;
        logic [31:0] gw_addr;
        logic [31:0] enb_teid;
        logic [15:0] gw_port;
        logic [31:0] gw_teid;
    } flow_t;

    // passed from cell to cell, lowest index first
    typedef struct packed {
        logic  free_seen;
        logic  hit;
        flow_t flow;
    } link_t;

    function automatic logic [63:0] id_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (4'(b) < len)
                m[b*8 +: 8] = 8'hff;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

@@ hdl/thpt_cell.sv @@
// One table entry: key compare, merge, completion check and clear.
// Depends on thpt_pkg. Chained by tunnel_half_context_pairing_table_top.
`default_nettype none

module thpt_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           add_en,
    input  wire thpt_pkg::req_t req,
    input  wire logic           any_match,
    input  wire logic           match_in,
    output logic                match_out,
    input  wire thpt_pkg::link_t link_in,
    output thpt_pkg::link_t     link_out
);

    logic              valid_reg;
    logic              valid_next;
    thpt_pkg::entry_t  entry_reg;
    thpt_pkg::entry_t  entry_next;
    thpt_pkg::entry_t  merged;
    logic              match;
    logic              free;
    logic              sel;
    logic              complete;
    thpt_pkg::flow_t   mine;

    assign match = valid_reg
                && entry_reg.bearer == req.fields.bearer
                && entry_reg.sub_len == req.fields.sub_len
                && entry_reg.sub == req.fields.sub;
    assign free = !valid_reg;
    assign sel  = add_en && (any_match ? (match && !match_in)
                                       : (free && !link_in.free_seen));

    always_comb
    begin
        merged = entry_reg;
        if (!match)
        begin
            merged.sub     = req.fields.sub;
            merged.sub_len = req.fields.sub_len;
        end
        merged.bearer = req.fields.bearer;
        if (req.opcode == thpt_pkg::OP_ACCESS_ADD)
        begin
            merged.station_ip   = req.fields.station_ip;
            merged.gateway_ip   = req.fields.gateway_ip;
            merged.gateway_port = req.fields.gateway_port;
            merged.station_teid = req.fields.station_teid;
            merged.access_teid  = req.fields.access_teid;
        end
        else
        begin
            merged.user_ip          = req.fields.user_ip;
            merged.core_local_teid  = req.fields.core_local_teid;
            merged.core_remote_teid = req.fields.core_remote_teid;
        end
    end

    assign complete = merged.bearer != '0 && merged.user_ip != '0
                   && merged.station_ip != '0 && merged.gateway_ip != '0
                   && merged.station_teid != '0 && merged.access_teid != '0
                   && merged.core_local_teid != '0 && merged.core_remote_teid != '0;

    always_comb
    begin
        mine.ue_addr  = merged.user_ip;
        mine.enb_addr = merged.station_ip;
        mine.gw_addr  = merged.gateway_ip;
        mine.enb_teid = merged.station_teid;
        mine.gw_port  = merged.gateway_port;
        mine.gw_teid  = merged.access_teid;
    end

    assign match_out          = match_in | match;
    assign link_out.free_seen = link_in.free_seen | free;
    assign link_out.hit       = link_in.hit | (sel && complete);
    assign link_out.flow      = link_in.flow | ((sel && complete) ? mine : '0);

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (sel)
        begin
            if (complete)
            begin
                valid_next = 1'b0;
                entry_next = '0;
            end
            else
            begin
                valid_next = 1'b1;
                entry_next = merged;
            end
        end
    end

    // entry contents are architectural state and must read zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            entry_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            entry_reg <= entry_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/tunnel_half_context_pairing_table_top.sv @@
// Top level of the tunnel half-context pairing table: request register,
// row of thpt_cell entries, result register. Depends on thpt_pkg, thpt_cell.
//
//   port group      role      flow control
//   req_*  + fields request   req_valid / req_stall
//   rsp_*  + flow_* result    rsp_valid / rsp_stall
//   cfg_we, cfg_wdata config  write on cfg_we, no wait
//
// Each word is first held in the request register, then takes the
// compare/merge pass along the cell row, which writes the table and the
// result register together. The next word is taken once the request
// register is free. A held result blocks the pass until it is taken.
// Reset empties all entries and sets the remote port to 2152.
`default_nettype none

module tunnel_half_context_pairing_table_top #(
    parameter int TABLE_ENTRIES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,

    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [1:0]  opcode,
    input  wire logic [63:0] subscriber_id,
    input  wire logic [3:0]  subscriber_id_len,
    input  wire logic [3:0]  bearer_id,
    input  wire logic [31:0] user_ip,
    input  wire logic [31:0] base_station_ip,
    input  wire logic [31:0] gateway_ip,
    input  wire logic [15:0] gateway_port,
    input  wire logic [31:0] base_station_teid,
    input  wire logic [31:0] access_local_teid,
    input  wire logic [31:0] core_local_teid,
    input  wire logic [31:0] core_remote_teid,

    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic [2:0]       status,
    output logic [31:0]      flow_inner_ip,
    output logic [31:0]      flow_remote_ip,
    output logic [31:0]      flow_local_ip,
    output logic [15:0]      flow_remote_port,
    output logic [31:0]      flow_remote_teid,
    output logic [15:0]      flow_local_port,
    output logic [31:0]      flow_local_teid
);

    logic [15:0]       port_reg;
    logic              pend_reg;
    logic              pend_next;
    thpt_pkg::req_t    req_reg;
    thpt_pkg::req_t    req_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    logic [2:0]        status_reg;
    logic [2:0]        status_next;
    thpt_pkg::flow_t   flow_reg;
    thpt_pkg::flow_t   flow_next;
    logic [15:0]       rport_reg;
    logic [15:0]       rport_next;

    logic              accept;
    logic              exec;
    logic              is_add;
    logic              add_en;
    logic              any_match;
    logic [TABLE_ENTRIES:0] match_chain;
    thpt_pkg::link_t   link [TABLE_ENTRIES+1];

    assign accept = req_valid && !req_stall;
    assign exec   = pend_reg && (!rsp_valid_reg || !rsp_stall);
    assign is_add = req_reg.opcode == thpt_pkg::OP_ACCESS_ADD
                 || req_reg.opcode == thpt_pkg::OP_CORE_ADD;
    assign add_en = exec && is_add && req_reg.fields.bearer != '0;

    always_comb
    begin
        req_next                         = req_reg;
        req_next.opcode                  = opcode;
        req_next.fields.sub              = subscriber_id
                                         & thpt_pkg::id_mask(subscriber_id_len);
        req_next.fields.sub_len          = subscriber_id_len;
        req_next.fields.bearer           = bearer_id;
        req_next.fields.user_ip          = user_ip;
        req_next.fields.station_ip       = base_station_ip;
        req_next.fields.gateway_ip       = gateway_ip;
        req_next.fields.gateway_port     = gateway_port;
        req_next.fields.station_teid     = base_station_teid;
        req_next.fields.access_teid      = access_local_teid;
        req_next.fields.core_local_teid  = core_local_teid;
        req_next.fields.core_remote_teid = core_remote_teid;
    end

    assign match_chain[0] = 1'b0;
    assign link[0]        = '0;
    assign any_match      = match_chain[TABLE_ENTRIES];

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        thpt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .add_en    (add_en),
            .req       (req_reg),
            .any_match (any_match),
            .match_in  (match_chain[i]),
            .match_out (match_chain[i+1]),
            .link_in   (link[i]),
            .link_out  (link[i+1])
        );
    end

    always_comb
    begin
        pend_next      = pend_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        flow_next      = flow_reg;
        rport_next     = rport_reg;
        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
        if (accept)
            pend_next = 1'b1;
        if (exec)
        begin
            pend_next      = 1'b0;
            rsp_valid_next = 1'b1;
            flow_next      = '0;
            rport_next     = '0;
            priority if (!is_add)
                status_next = thpt_pkg::ST_DELETE;
            else if (req_reg.fields.bearer == '0)
                status_next = thpt_pkg::ST_REJECT;
            else if (!any_match && !link[TABLE_ENTRIES].free_seen)
                status_next = thpt_pkg::ST_FULL;
            else if (link[TABLE_ENTRIES].hit)
            begin
                status_next = thpt_pkg::ST_COMPLETE;
                flow_next   = link[TABLE_ENTRIES].flow;
                rport_next  = port_reg;
            end
            else
                status_next = thpt_pkg::ST_STORED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_reg      <= thpt_pkg::REMOTE_PORT_RESET;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                port_reg <= cfg_wdata;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= req_next;
        status_reg <= status_next;
        flow_reg   <= flow_next;
        rport_reg  <= rport_next;
    end

    assign req_stall        = pend_reg;
    assign rsp_valid        = rsp_valid_reg;
    assign status           = status_reg;
    assign flow_inner_ip    = flow_reg.ue_addr;
    assign flow_remote_ip   = flow_reg.enb_addr;
    assign flow_local_ip    = flow_reg.gw_addr;
    assign flow_remote_port = rport_reg;
    assign flow_remote_teid = flow_reg.enb_teid;
    assign flow_local_port  = flow_reg.gw_port;
    assign flow_local_teid  = flow_reg.gw_teid;

    a_pass_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && (!rsp_valid_reg || !rsp_stall)) |=> (rsp_valid_reg && !pend_reg))
        else $error("pending request did not reach the result register");

    a_flow_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && status_reg == thpt_pkg::ST_COMPLETE) |->
        (flow_reg.ue_addr != '0 && flow_reg.enb_addr != '0 && flow_reg.gw_addr != '0
         && flow_reg.enb_teid != '0 && flow_reg.gw_teid != '0))
        else $error("completed flow carries a zero field");

    a_flow_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && status_reg != thpt_pkg::ST_COMPLETE) |->
        (flow_reg == '0 && rport_reg == '0))
        else $error("flow fields nonzero without a completed flow");

endmodule

`default_nettype wire

@@ tb/tunnel_half_context_pairing_table_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for tunnel_half_context_pairing_table_top: a queue-fed driver,
// a stalling monitor and a local model of the pairing table that predicts each result word.
// Depends on thpt_pkg and the top level RTL; needs no files or arguments.

module tunnel_half_context_pairing_table_top_test;

    localparam int ENTRIES          = 8;
    localparam int POOL_KEYS        = 11;
    localparam int QUIET_LIMIT      = 2000;
    localparam int RANDOM_PER_PHASE = 150;

    typedef struct packed {
        logic [2:0]      status;
        logic [15:0]     udp_port;
        thpt_pkg::flow_t flow;
    } flow_word_t;

    typedef struct packed {
        logic [63:0] sub;
        logic [3:0]  len;
        logic [3:0]  bearer;
    } key_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           cfg_we    = 1'b0;
    logic [15:0]    cfg_wdata = '0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    thpt_pkg::req_t cur_word  = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    logic [2:0]     status;
    logic [31:0]    flow_inner_ip;
    logic [31:0]    flow_remote_ip;
    logic [31:0]    flow_local_ip;
    logic [15:0]    flow_remote_port;
    logic [31:0]    flow_remote_teid;
    logic [15:0]    flow_local_port;
    logic [31:0]    flow_local_teid;

    // model of the table and the port register
    thpt_pkg::entry_t half_table [ENTRIES];
    logic             half_used  [ENTRIES];
    logic [15:0]      port_reg;

    key_t        key_pool [POOL_KEYS];
    int          key_lens [POOL_KEYS] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 15};

    thpt_pkg::req_t setup_words [$];
    flow_word_t     pending_flows [$];

    int errors       = 0;
    int burst_left   = 0;
    int gap_left     = 0;
    int stall_mode   = 0;
    int stall_left   = 0;
    int quiet_cycles = 0;

    tunnel_half_context_pairing_table_top #(.TABLE_ENTRIES(ENTRIES)) DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .req_valid         (req_valid),
        .req_stall         (req_stall),
        .opcode            (cur_word.opcode),
        .subscriber_id     (cur_word.fields.sub),
        .subscriber_id_len (cur_word.fields.sub_len),
        .bearer_id         (cur_word.fields.bearer),
        .user_ip           (cur_word.fields.user_ip),
        .base_station_ip   (cur_word.fields.station_ip),
        .gateway_ip        (cur_word.fields.gateway_ip),
        .gateway_port      (cur_word.fields.gateway_port),
        .base_station_teid (cur_word.fields.station_teid),
        .access_local_teid (cur_word.fields.access_teid),
        .core_local_teid   (cur_word.fields.core_local_teid),
        .core_remote_teid  (cur_word.fields.core_remote_teid),
        .rsp_valid         (rsp_valid),
        .rsp_stall         (rsp_stall),
        .status            (status),
        .flow_inner_ip     (flow_inner_ip),
        .flow_remote_ip    (flow_remote_ip),
        .flow_local_ip     (flow_local_ip),
        .flow_remote_port  (flow_remote_port),
        .flow_remote_teid  (flow_remote_teid),
        .flow_local_port   (flow_local_port),
        .flow_local_teid   (flow_local_teid)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic [63:0] id_bytes_mask(input logic [3:0] len);
        if (len >= 4'd8)
            return '1;
        return (64'd1 << (len * 8)) - 64'd1;
    endfunction

    // lookup, allocate, merge and completion for one accepted word
    function automatic flow_word_t pair_halves(input thpt_pkg::req_t w);
        flow_word_t       r;
        logic [63:0]      key;
        int               slot;
        thpt_pkg::entry_t e;
        r    = '0;
        slot = -1;
        key  = w.fields.sub & id_bytes_mask(w.fields.sub_len);
        if (w.opcode == thpt_pkg::OP_ACCESS_DEL || w.opcode == thpt_pkg::OP_CORE_DEL)
        begin
            r.status = thpt_pkg::ST_DELETE;
            return r;
        end
        if (w.fields.bearer == 4'd0)
        begin
            r.status = thpt_pkg::ST_REJECT;
            return r;
        end
        for (int k = 0; k < ENTRIES; k++)
        begin
            if (slot < 0 && half_used[k] && half_table[k].bearer == w.fields.bearer &&
                half_table[k].sub_len == w.fields.sub_len && half_table[k].sub == key)
                slot = k;
        end
        if (slot < 0)
        begin
            for (int k = 0; k < ENTRIES; k++)
            begin
                if (slot < 0 && !half_used[k])
                    slot = k;
            end
            if (slot < 0)
            begin
                r.status = thpt_pkg::ST_FULL;
                return r;
            end
            half_table[slot].sub     = key;
            half_table[slot].sub_len = w.fields.sub_len;
        end
        e = half_table[slot];
        e.bearer = w.fields.bearer;
        if (w.opcode == thpt_pkg::OP_ACCESS_ADD)
        begin
            e.station_ip   = w.fields.station_ip;
            e.gateway_ip   = w.fields.gateway_ip;
            e.gateway_port = w.fields.gateway_port;
            e.station_teid = w.fields.station_teid;
            e.access_teid  = w.fields.access_teid;
        end
        else
        begin
            e.user_ip          = w.fields.user_ip;
            e.core_local_teid  = w.fields.core_local_teid;
            e.core_remote_teid = w.fields.core_remote_teid;
        end
        if (e.user_ip != 0 && e.station_ip != 0 && e.gateway_ip != 0 &&
            e.station_teid != 0 && e.access_teid != 0 &&
            e.core_local_teid != 0 && e.core_remote_teid != 0)
        begin
            r.status         = thpt_pkg::ST_COMPLETE;
            r.udp_port       = port_reg;
            r.flow.ue_addr   = e.user_ip;
            r.flow.enb_addr  = e.station_ip;
            r.flow.gw_addr   = e.gateway_ip;
            r.flow.enb_teid  = e.station_teid;
            r.flow.gw_port   = e.gateway_port;
            r.flow.gw_teid   = e.access_teid;
            half_table[slot] = '0;
            half_used[slot]  = 1'b0;
        end
        else
        begin
            r.status         = thpt_pkg::ST_STORED;
            half_table[slot] = e;
            half_used[slot]  = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [31:0] pick32(input int zero_odds);
        logic [31:0] v;
        if (zero_odds > 0 && $urandom_range(0, zero_odds - 1) == 0)
            return '0;
        if ($urandom_range(0, 15) == 0)
            return '1;
        v = $urandom;
        return (v == 0) ? 32'd1 : v;
    endfunction

    // word for a pool key; bytes beyond the length carry junk
    function automatic thpt_pkg::req_t pool_word(input int k, input logic [1:0] op,
                                                 input int zero_odds);
        thpt_pkg::req_t w;
        logic [63:0]    m;
        m = id_bytes_mask(key_pool[k].len);
        w.opcode                  = op;
        w.fields.sub              = (key_pool[k].sub & m) | ({$urandom, $urandom} & ~m);
        w.fields.sub_len          = key_pool[k].len;
        w.fields.bearer           = key_pool[k].bearer;
        w.fields.user_ip          = pick32(zero_odds);
        w.fields.station_ip       = pick32(zero_odds);
        w.fields.gateway_ip       = pick32(zero_odds);
        w.fields.gateway_port     = 16'($urandom_range(0, 65535));
        w.fields.station_teid     = pick32(zero_odds);
        w.fields.access_teid      = pick32(zero_odds);
        w.fields.core_local_teid  = pick32(zero_odds);
        w.fields.core_remote_teid = pick32(zero_odds);
        return w;
    endfunction

    function automatic logic [1:0] any_add();
        return $urandom_range(0, 1) ? thpt_pkg::OP_CORE_ADD : thpt_pkg::OP_ACCESS_ADD;
    endfunction

    task automatic queue_directed();
        thpt_pkg::req_t w;
        w = pool_word(0, thpt_pkg::OP_ACCESS_DEL, 0);
        setup_words.push_back(w);
        w = pool_word(0, thpt_pkg::OP_CORE_DEL, 0);
        setup_words.push_back(w);
        w = pool_word(2, thpt_pkg::OP_ACCESS_ADD, 0);
        w.fields.bearer = '0;
        setup_words.push_back(w);
        w = pool_word(2, thpt_pkg::OP_CORE_ADD, 0);
        w.fields.bearer = '0;
        setup_words.push_back(w);
        // all ones everywhere, length fifteen
        w.fields = '1;
        w.opcode = thpt_pkg::OP_ACCESS_ADD;
        setup_words.push_back(w);
        w.opcode = thpt_pkg::OP_CORE_ADD;
        setup_words.push_back(w);
        // zero length, smallest nonzero fields, zero gateway port
        w = pool_word(0, thpt_pkg::OP_ACCESS_ADD, 0);
        w.fields.station_ip   = 32'd1;
        w.fields.gateway_ip   = 32'd1;
        w.fields.station_teid = 32'd1;
        w.fields.access_teid  = 32'd1;
        w.fields.gateway_port = '0;
        setup_words.push_back(w);
        w = pool_word(0, thpt_pkg::OP_CORE_ADD, 0);
        w.fields.user_ip          = 32'd1;
        w.fields.core_local_teid  = 32'd1;
        w.fields.core_remote_teid = 32'd1;
        setup_words.push_back(w);
        // length nine vs eight on the same identity: two separate entries
        setup_words.push_back(pool_word(9, thpt_pkg::OP_ACCESS_ADD, 0));
        setup_words.push_back(pool_word(8, thpt_pkg::OP_CORE_ADD, 0));
        setup_words.push_back(pool_word(9, thpt_pkg::OP_CORE_ADD, 0));
        setup_words.push_back(pool_word(8, thpt_pkg::OP_ACCESS_ADD, 0));
        // incomplete merge, then fixed up
        w = pool_word(1, thpt_pkg::OP_ACCESS_ADD, 0);
        w.fields.station_ip = '0;
        setup_words.push_back(w);
        setup_words.push_back(pool_word(1, thpt_pkg::OP_CORE_ADD, 0));
        setup_words.push_back(pool_word(1, thpt_pkg::OP_ACCESS_ADD, 0));
        // fill the table, then one more key
        for (int k = 0; k < ENTRIES; k++)
            setup_words.push_back(pool_word(k, thpt_pkg::OP_ACCESS_ADD, 0));
        setup_words.push_back(pool_word(8, thpt_pkg::OP_CORE_ADD, 0));
    endtask

    task automatic queue_random(input int count);
        int             r;
        thpt_pkg::req_t w;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                w = pool_word($urandom_range(0, POOL_KEYS - 1), any_add(), 12);
            else if (r < 88)
                w = pool_word($urandom_range(0, POOL_KEYS - 1),
                              $urandom_range(0, 1) ? thpt_pkg::OP_ACCESS_DEL
                                                   : thpt_pkg::OP_CORE_DEL, 12);
            else if (r < 94)
            begin
                w = pool_word($urandom_range(0, POOL_KEYS - 1), any_add(), 12);
                w.fields.bearer = '0;
            end
            else
                w = pool_word($urandom_range(0, POOL_KEYS - 1),
                              2'($urandom_range(0, 3)), 2);
            setup_words.push_back(w);
        end
    endtask

    task automatic drain();
        while (setup_words.size() != 0 || req_valid || pending_flows.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_port(input logic [15:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        port_reg = v;
    endtask

    // sender: bursts and gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else
        begin
            if (req_valid && !req_stall)
                pending_flows.push_back(pair_halves(cur_word));
            if (!req_valid || !req_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left  = gap_left - 1;
                    req_valid <= 1'b0;
                end
                else if (setup_words.size() != 0)
                begin
                    cur_word  <= setup_words.pop_front();
                    req_valid <= 1'b1;
                    burst_left = burst_left - 1;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 16);
                        case ($urandom_range(0, 9))
                            0, 1, 2: gap_left = 0;
                            9:       gap_left = $urandom_range(10, 24);
                            default: gap_left = $urandom_range(1, 6);
                        endcase
                    end
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // receiver: check, stall pattern, watchdog
    always @(posedge clk or negedge rst_n)
    begin
        flow_word_t got;
        flow_word_t exp;
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                got = {status, flow_remote_port, flow_inner_ip, flow_remote_ip, flow_local_ip,
                       flow_remote_teid, flow_local_port, flow_local_teid};
                if (pending_flows.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result word, status %0d", got.status);
                    errors++;
                end
                else
                begin
                    exp = pending_flows.pop_front();
                    if (got !== exp)
                    begin
                        if (errors < 10)
                        begin
                            $display("mismatch: status exp %0d got %0d", exp.status, got.status);
                            $display("  ue %h/%h enb %h/%h gw %h/%h",
                                     exp.flow.ue_addr, got.flow.ue_addr,
                                     exp.flow.enb_addr, got.flow.enb_addr,
                                     exp.flow.gw_addr, got.flow.gw_addr);
                            $display("  rport %h/%h rteid %h/%h lport %h/%h lteid %h/%h",
                                     exp.udp_port, got.udp_port,
                                     exp.flow.enb_teid, got.flow.enb_teid,
                                     exp.flow.gw_port, got.flow.gw_port,
                                     exp.flow.gw_teid, got.flow.gw_teid);
                        end
                        errors++;
                    end
                end
            end

            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
                $display("tunnel_half_context_pairing_table_top_test NOT OK");
                $finish;
            end
            else
            begin
                if (stall_left == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    stall_left = (stall_mode == 2) ? $urandom_range(1, 12)
                                                   : $urandom_range(4, 40);
                end
                stall_left--;
                case (stall_mode)
                    0:       rsp_stall <= 1'b0;
                    1:       rsp_stall <= 1'($urandom_range(0, 1));
                    default: rsp_stall <= 1'b1;
                endcase
            end
        end
    end

    initial
    begin
        for (int k = 0; k < ENTRIES; k++)
        begin
            half_table[k] = '0;
            half_used[k]  = 1'b0;
        end
        port_reg = thpt_pkg::REMOTE_PORT_RESET;
        for (int k = 0; k < POOL_KEYS; k++)
        begin
            key_pool[k].sub    = {$urandom, $urandom} & id_bytes_mask(4'(key_lens[k]));
            key_pool[k].len    = 4'(key_lens[k]);
            key_pool[k].bearer = 4'($urandom_range(1, 15));
        end
        key_pool[0].bearer = 4'd1;
        key_pool[9].sub    = key_pool[8].sub;
        key_pool[9].bearer = key_pool[8].bearer;
        key_pool[10]       = '1;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        queue_directed();
        queue_random(RANDOM_PER_PHASE);
        drain();
        write_port(16'h0000);
        queue_random(RANDOM_PER_PHASE);
        drain();
        write_port(16'hffff);
        queue_random(RANDOM_PER_PHASE);
        drain();
        write_port(16'($urandom));
        queue_random(RANDOM_PER_PHASE / 2);
        drain();
        queue_random(RANDOM_PER_PHASE / 2);
        drain();

        repeat (8) @(posedge clk);
        if (errors == 0 && pending_flows.size() == 0)
            $display("tunnel_half_context_pairing_table_top_test OK");
        else
            $display("tunnel_half_context_pairing_table_top_test NOT OK");
        $finish;
    end

endmodule
